[design/xr128_pkg.sv]
package xr128_pkg;

  typedef enum logic [2:0] {
    OP_RAW       = 3'd0,
    OP_RANGE     = 3'd1,
    OP_SEED_ONE  = 3'd2,
    OP_SEED_PAIR = 3'd3,
    OP_JUMP      = 3'd4,
    OP_LONG_JUMP = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_NORM,
    F_PUSH
  } f_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RAW,
    B_RANGE,
    B_CHECK,
    B_MIX_PREP,
    B_MIX_MUL,
    B_MIX_NEXT,
    B_JUMP
  } b_state_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] low;
    logic [63:0] span;
    logic [5:0]  lz;
    logic        span_zero;
    logic [63:0] seed_a;
    logic [63:0] seed_b;
  } cmd_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } xr_state_t;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] NORM_LAST = 3'd5;

  localparam logic [63:0] SPLITMIX_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SPLITMIX_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SPLITMIX_MUL2  = 64'h94D049BB133111EB;

  localparam logic [127:0] JUMP_POLY      = {64'h170865df4b3201fc, 64'hdf900294d8f554a5};
  localparam logic [127:0] LONG_JUMP_POLY = {64'hdddf9b1090aa7ac1, 64'hd2a98b26625eee7b};

  function automatic xr_state_t xr_step(xr_state_t s);
    xr_state_t   r;
    logic [63:0] bx;
    bx  = s.b ^ s.a;
    r.a = {s.a[39:0], s.a[63:40]} ^ bx ^ {bx[47:0], 16'd0};
    r.b = {bx[26:0], bx[63:27]};
    return r;
  endfunction

endpackage

[design/xoroshiro128_plus_generator.sv]
// channel  dir  tdata (low bit up)                                   tuser
// s_*      in   range_low 64, range_high 64, seed_first 64,          operation 3
//               seed_second 64
// m_*      out  value 64, coin 1, fraction 24, zero fill 7           -
//
// Front takes one transaction at a time and queues it, waiting while the queue is full;
// a range draw first runs a leading-zero search of the span, one halving a cycle.
// Back: a range draw retries until it fits the span; single-word seed uses splitmix
// (three 32x32 partial products per multiply); jumps walk the polynomial bits.
// Reset: state words 1 and 0, queue and output register empty.
// A stalled m_* holds one result; the back waits only when it must load a second one.
module xoroshiro128_plus_generator #(
  parameter int QUEUE_DEPTH = xr128_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,  // range_low, range_high, seed_first, seed_second
  input  logic [2:0]   s_tuser,  // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata   // value, coin, fraction, zero fill
);
  import xr128_pkg::*;

  cmd_t q_in, q_out;
  logic q_push, q_full, q_pop, q_empty;

  xr128_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (q_push),
    .cmd      (q_in),
    .full     (q_full)
  );

  xr128_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  xr128_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .head     (q_out),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[design/xr128_front.sv]
module xr128_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [255:0]         s_tdata,  // range_low, range_high, seed_first, seed_second
  input  logic [2:0]           s_tuser,  // operation
  output logic                 push,
  output xr128_pkg::cmd_t      cmd,
  input  logic                 full
);
  import xr128_pkg::*;

  f_state_t    state, state_next;
  logic [2:0]  step;
  logic [63:0] w;
  logic [5:0]  norm_amt;
  logic [63:0] norm_hi;
  logic        norm_take;
  logic        accept;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    norm_amt  = 6'd32 >> step;
    norm_hi   = ~({64{1'b1}} >> norm_amt);
    norm_take = (w & norm_hi) == 64'd0;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == OP_RANGE) begin
            state_next = F_NORM;
          end else if (s_tuser inside {OP_RAW, OP_SEED_ONE, OP_SEED_PAIR,
                                       OP_JUMP, OP_LONG_JUMP}) begin
            state_next = F_PUSH;
          end
        end
      end
      F_NORM: begin
        if (step == NORM_LAST) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    case (state)
      F_IDLE:  s_tready = 1'b1;
      F_PUSH:  push = !full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the command, then leading-zero count of the span, binary search one halving per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.op        <= op_t'(s_tuser);
      cmd.low       <= s_tdata[63:0];
      cmd.span      <= s_tdata[127:64] - s_tdata[63:0];
      cmd.span_zero <= s_tdata[127:64] == s_tdata[63:0];
      cmd.lz        <= 6'd0;
      cmd.seed_a    <= s_tdata[191:128];
      cmd.seed_b    <= s_tdata[255:192];
      w             <= s_tdata[127:64] - s_tdata[63:0];
      step          <= 3'd0;
    end else if (state == F_NORM) begin
      if (norm_take) begin
        w      <= w << norm_amt;
        cmd.lz <= cmd.lz + norm_amt;
      end
      step <= step + 3'd1;
    end
  end

endmodule

[design/xr128_queue.sv]
module xr128_queue #(
  parameter int DEPTH = xr128_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xr128_pkg::cmd_t din,
  output logic            full,
  input  logic            pop,
  output xr128_pkg::cmd_t dout,
  output logic            empty
);
  import xr128_pkg::*;

  // DEPTH of two or more
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

endmodule

[design/xr128_back.sv]
module xr128_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  xr128_pkg::cmd_t head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [95:0]     m_tdata  // value, coin, fraction, zero fill
);
  import xr128_pkg::*;

  b_state_t    state, state_next;
  logic [63:0] sa, sb;
  cmd_t        cmd;
  logic [63:0] sum;
  xr_state_t   stepped;
  xr_state_t   st_next;
  logic        st_we;
  logic        out_free;
  logic        load_out;

  logic [63:0] out_value, out_value_next;
  logic        out_coin, out_coin_next;
  logic [23:0] out_frac, out_frac_next;

  logic [63:0] cand;
  logic        range_ok;

  logic [63:0] mix_acc, mix_first, mix_out;
  logic [63:0] mul_x, mul_m, prod, prod_next, mul_p;
  logic [31:0] mul_a, mul_b;
  logic [1:0]  part, mul_k;

  logic [6:0]   jump_idx;
  logic [63:0]  jump_na, jump_nb, jump_na_n, jump_nb_n;
  logic [127:0] poly;
  logic         jump_last;

  assign sum      = sa + sb;
  assign stepped  = xr_step('{a: sa, b: sb});
  assign out_free = !m_tvalid || m_tready;
  assign range_ok = cand <= cmd.span;
  assign m_tdata  = {7'd0, out_frac, out_coin, out_value};

  // one 32x32 partial product per cycle, low 64 bits of the 64x64 product
  always_comb begin
    mul_m     = mul_k[0] ? SPLITMIX_MUL2 : SPLITMIX_MUL1;
    mul_a     = (part == 2'd2) ? mul_x[63:32] : mul_x[31:0];
    mul_b     = (part == 2'd1) ? mul_m[63:32] : mul_m[31:0];
    mul_p     = 64'(mul_a) * 64'(mul_b);
    prod_next = (part == 2'd0) ? mul_p : prod + {mul_p[31:0], 32'd0};
    mix_out   = prod ^ (prod >> 31);
  end

  always_comb begin
    poly      = (cmd.op == OP_LONG_JUMP) ? LONG_JUMP_POLY : JUMP_POLY;
    jump_na_n = poly[jump_idx] ? (jump_na ^ sa) : jump_na;
    jump_nb_n = poly[jump_idx] ? (jump_nb ^ sb) : jump_nb;
    jump_last = jump_idx == 7'd127;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          case (head.op)
            OP_RAW:      state_next = B_RAW;
            OP_RANGE:    state_next = B_RANGE;
            OP_SEED_ONE: state_next = B_MIX_PREP;
            OP_JUMP,
            OP_LONG_JUMP: state_next = B_JUMP;
            default:     state_next = B_IDLE;
          endcase
        end
      end
      B_RAW:      if (out_free) state_next = B_IDLE;
      B_RANGE:    state_next = B_CHECK;
      B_CHECK: begin
        if (!range_ok) begin
          state_next = B_RANGE;
        end else if (out_free) begin
          state_next = B_IDLE;
        end
      end
      B_MIX_PREP: state_next = B_MIX_MUL;
      B_MIX_MUL:  if (part == 2'd2) state_next = B_MIX_NEXT;
      B_MIX_NEXT: begin
        if (!mul_k[0]) begin
          state_next = B_MIX_MUL;
        end else if (!mul_k[1]) begin
          state_next = B_MIX_PREP;
        end else begin
          state_next = B_IDLE;
        end
      end
      B_JUMP:     if (jump_last) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    load_out       = 1'b0;
    st_we          = 1'b0;
    st_next        = stepped;
    out_value_next = sum;
    out_coin_next  = sum[63];
    out_frac_next  = sum[63:40];
    case (state)
      B_IDLE: begin
        pop = !empty;
        if (!empty && head.op == OP_SEED_PAIR) begin
          st_we   = 1'b1;
          st_next = '{a: head.seed_a, b: head.seed_b};
        end
      end
      B_RAW: begin
        if (out_free) begin
          load_out = 1'b1;
          st_we    = 1'b1;
        end
      end
      B_RANGE: st_we = 1'b1;
      B_CHECK: begin
        out_value_next = cmd.low + cand;
        out_coin_next  = 1'b0;
        out_frac_next  = 24'd0;
        load_out       = range_ok && out_free;
      end
      B_MIX_NEXT: begin
        if (mul_k == 2'd3) begin
          st_we   = 1'b1;
          st_next = '{a: mix_first, b: mix_out};
        end
      end
      B_JUMP: begin
        st_we = 1'b1;
        if (jump_last) begin
          st_next = '{a: jump_na_n, b: jump_nb_n};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      sa       <= 64'd1;
      sb       <= 64'd0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= load_out || (m_tvalid && !m_tready);
      if (st_we) begin
        sa <= st_next.a;
        sb <= st_next.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value <= out_value_next;
      out_coin  <= out_coin_next;
      out_frac  <= out_frac_next;
    end
    case (state)
      B_IDLE: begin
        if (pop) begin
          cmd      <= head;
          mix_acc  <= head.seed_a + SPLITMIX_GAMMA;
          mul_k    <= 2'd0;
          jump_idx <= 7'd0;
          jump_na  <= 64'd0;
          jump_nb  <= 64'd0;
        end
      end
      B_RANGE: cand <= cmd.span_zero ? 64'd0 : (sum >> cmd.lz);
      B_MIX_PREP: begin
        mul_x <= mix_acc ^ (mix_acc >> 30);
        part  <= 2'd0;
      end
      B_MIX_MUL: begin
        prod <= prod_next;
        part <= part + 2'd1;
      end
      B_MIX_NEXT: begin
        if (!mul_k[0]) begin
          mul_x <= prod ^ (prod >> 27);
          part  <= 2'd0;
        end else if (!mul_k[1]) begin
          mix_first <= mix_out;
          mix_acc   <= mix_acc + SPLITMIX_GAMMA;
        end
        mul_k <= mul_k + 2'd1;
      end
      B_JUMP: begin
        jump_na  <= jump_na_n;
        jump_nb  <= jump_nb_n;
        jump_idx <= jump_idx + 7'd1;
      end
      default: ;
    endcase
  end

  a_jump_ends: assert property (@(posedge clk) disable iff (rst)
    (state == B_JUMP && jump_last) |=> state == B_IDLE)
    else $error("jump did not finish after 128 steps");

  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_CHECK && load_out) |=>
      ((out_value - $past(cmd.low)) <= $past(cmd.span)) && !out_coin && out_frac == 24'd0)
    else $error("ranged result outside span");

  a_seed_pair: assert property (@(posedge clk) disable iff (rst)
    (pop && head.op == OP_SEED_PAIR) |=>
      (sa == $past(head.seed_a)) && (sb == $past(head.seed_b)))
    else $error("pair seed not loaded");

endmodule
